// ===== hdl/bptc_pkg.sv =====
// Shared constants and types for the barometer pressure and temperature compensation core.
package bptc_pkg;

    localparam int RAW_W     = 24;
    localparam int PRESS_W   = 24;
    localparam int TEMP_W    = 16;
    localparam int CFG_W     = 24;
    localparam int CFG_IDX_W = 3;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t REG_TEMP_COEFFS   = 3'd0;
    localparam cfg_idx_t REG_PRESS_OFFSET  = 3'd1;
    localparam cfg_idx_t REG_PRESS_LIN     = 3'd2;
    localparam cfg_idx_t REG_TEMP_ON_PRESS = 3'd3;
    localparam cfg_idx_t REG_CROSS_LIN     = 3'd4;
    localparam cfg_idx_t REG_PRESS_QUAD    = 3'd5;
    localparam cfg_idx_t REG_CROSS_QUAD    = 3'd6;
    localparam cfg_idx_t REG_PRESS_CUBIC   = 3'd7;

    // 253952 = 31 * 2^13; divide by 31 through a reciprocal, exact below 2^24
    localparam int                 SCALE_SHIFT = 13;
    localparam int                 DIV_SHIFT   = 5;
    localparam int                 RECIP_W     = 25;
    localparam logic [RECIP_W-1:0] RECIP       = 25'd17318417;
    localparam int                 RECIP_SHIFT = 29;
    localparam int                 QUOT_W      = 19;
    localparam int                 REM_W       = 5;

    localparam int CENTI      = 100;
    localparam int PRESS_INT_W = 33;
    localparam int TEMP_INT_W  = 24;

    localparam int PRESS_MAX = 8388607;
    localparam int PRESS_MIN = -8388608;
    localparam int TEMP_MAX  = 32767;
    localparam int TEMP_MIN  = -32768;

    localparam int LATENCY = 18;

endpackage

// ===== hdl/bptc_mul.sv =====
// Three-stage signed multiplier built from four registered partial products.
module bptc_mul #(
    parameter int WA = 27,
    parameter int WB = 42
)(
    input  logic                    clk,
    input  logic signed [WA-1:0]    a,
    input  logic signed [WB-1:0]    b,
    output logic signed [WA+WB-1:0] p
);

    localparam int KA = WA / 2;
    localparam int KB = WB / 2;
    localparam int HA = WA - KA;
    localparam int HB = WB - KB;
    localparam int LW = WA + KB;
    localparam int HW = WA + HB;
    localparam int PW = WA + WB;

    logic        [KA-1:0] al;
    logic signed [HA-1:0] ah;
    logic        [KB-1:0] bl;
    logic signed [HB-1:0] bh;

    logic        [KA+KB-1:0] pp_ll_reg;
    logic signed [HA+KB:0]   pp_hl_reg;
    logic signed [KA+HB:0]   pp_lh_reg;
    logic signed [HA+HB-1:0] pp_hh_reg;
    logic signed [LW-1:0]    lo_reg;
    logic signed [HW-1:0]    hi_reg;
    logic signed [PW-1:0]    p_reg;

    assign al = a[KA-1:0];
    assign ah = a[WA-1:KA];
    assign bl = b[KB-1:0];
    assign bh = b[WB-1:KB];

    always_ff @(posedge clk)
    begin
        pp_ll_reg <= al * bl;
        pp_hl_reg <= ah * $signed({1'b0, bl});
        pp_lh_reg <= $signed({1'b0, al}) * bh;
        pp_hh_reg <= ah * bh;
        lo_reg    <= LW'(pp_ll_reg) + (LW'(pp_hl_reg) << KA);
        hi_reg    <= HW'(pp_lh_reg) + (HW'(pp_hh_reg) << KA);
        p_reg     <= PW'(lo_reg) + (PW'(hi_reg) << KB);
    end

    assign p = p_reg;

endmodule

// ===== hdl/baro_pressure_temp_compensation_core.sv =====
// An accepted request enters the valid pipeline, whose last stage drives the done strobe.
// Throughput: one pressure and temperature pair per cycle through a fixed pipeline while busy is low.
// Results appear with done and hold until the next result; the receiver cannot stall, so nothing backs up.
// Reset clears the valid pipeline, the coefficients and the outputs to zero.
// busy is high during reset, drops at the clock after reset is released, and stays low afterwards.
module baro_pressure_temp_compensation_core
    import bptc_pkg::*;
#(
    parameter int FRAC_BITS = 20
)(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic signed [RAW_W-1:0]   raw_press,
    input  logic signed [RAW_W-1:0]   raw_temp,
    output logic                      done,
    output logic signed [PRESS_W-1:0] press_pa,
    output logic signed [TEMP_W-1:0]  temp_centi,
    input  logic                      cfg_wr_en,
    input  cfg_idx_t                  cfg_index,
    input  logic [CFG_W-1:0]          cfg_data
);

    localparam int SH  = FRAC_BITS - SCALE_SHIFT;
    localparam int RW  = REM_W + SH;
    localparam int MW  = QUOT_W + SH;
    localparam int PW  = MW + 1;
    localparam int X1W = FRAC_BITS + 22;
    localparam int X2W = FRAC_BITS + 27;
    localparam int ZW  = FRAC_BITS + 27;
    localparam int SW  = FRAC_BITS + 33;
    localparam int TSW = FRAC_BITS + 18;
    localparam int TMW = FRAC_BITS + 24;

    localparam logic signed [SW-1:0]  PRESS_RND = (SW'(1) <<< FRAC_BITS) - SW'(1);
    localparam logic signed [TMW-1:0] TEMP_RND  = (TMW'(1) <<< FRAC_BITS) - TMW'(1);

    logic                busy_reg;
    logic [1:LATENCY]    vld_reg;
    logic                accept;

    logic        [23:0] temp_coeffs_reg;
    logic signed [19:0] press_offset_reg;
    logic signed [19:0] press_lin_reg;
    logic signed [15:0] temp_on_press_reg;
    logic signed [15:0] cross_lin_reg;
    logic signed [15:0] press_quad_reg;
    logic signed [15:0] cross_quad_reg;
    logic signed [15:0] press_cubic_reg;

    logic signed [11:0] c0;
    logic signed [11:0] c1;

    logic signed [RAW_W-1:0] raw [2];
    logic signed [PW-1:0]    smp [2];

    logic signed [PW-1:0]  pd_reg [6:11];
    logic signed [PW-1:0]  td_reg [6:14];
    logic signed [X1W-1:0] pd_reg_unused;

    logic signed [PW+15:0] pc30_full;
    logic signed [PW+15:0] pc21_full;
    logic signed [PW+15:0] tc01_full;
    logic signed [X1W-1:0] pc30_reg;
    logic signed [X1W-1:0] pc21_reg;
    logic signed [X1W-1:0] tc01_reg;
    logic signed [X1W-1:0] x1_reg;
    logic signed [X1W-1:0] y1_reg;
    logic signed [X1W-1:0] bd_reg [7:15];

    logic signed [PW+X1W-1:0] m1;
    logic signed [PW+X1W-1:0] m2;
    logic signed [X2W-1:0]    x2_reg;
    logic signed [ZW-1:0]     z_reg;
    logic signed [PW+X2W-1:0] m3;
    logic signed [PW+ZW-1:0]  m4;

    logic signed [SW-1:0]          s_reg;
    logic signed [SW-1:0]          pres_reg;
    logic signed [SW-1:0]          pres_rnd;
    logic signed [PRESS_INT_W-1:0] pint_reg;

    logic signed [PW+11:0]        tc1_full;
    logic signed [TSW-1:0]        tc1_reg;
    logic signed [TSW-1:0]        tsum_reg;
    logic signed [TMW-1:0]        tm_reg;
    logic signed [TMW-1:0]        tm_rnd;
    logic signed [TEMP_INT_W-1:0] tint;

    logic signed [PRESS_W-1:0] press_pa_reg;
    logic signed [PRESS_W-1:0] press_next;
    logic signed [TEMP_W-1:0]  temp_centi_reg;
    logic signed [TEMP_W-1:0]  temp_next;

    assign accept = start & ~busy_reg;
    assign busy   = busy_reg;
    assign done   = vld_reg[LATENCY];

    assign c0 = $signed(temp_coeffs_reg[23:12]);
    assign c1 = $signed(temp_coeffs_reg[11:0]);

    assign raw[0] = raw_press;
    assign raw[1] = raw_temp;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
            vld_reg  <= '0;
        end
        else
        begin
            busy_reg <= 1'b0;
            vld_reg  <= {accept, vld_reg[1:LATENCY-1]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_coeffs_reg   <= '0;
            press_offset_reg  <= '0;
            press_lin_reg     <= '0;
            temp_on_press_reg <= '0;
            cross_lin_reg     <= '0;
            press_quad_reg    <= '0;
            cross_quad_reg    <= '0;
            press_cubic_reg   <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_TEMP_COEFFS:   temp_coeffs_reg   <= cfg_data;
                REG_PRESS_OFFSET:  press_offset_reg  <= cfg_data[19:0];
                REG_PRESS_LIN:     press_lin_reg     <= cfg_data[19:0];
                REG_TEMP_ON_PRESS: temp_on_press_reg <= cfg_data[15:0];
                REG_CROSS_LIN:     cross_lin_reg     <= cfg_data[15:0];
                REG_PRESS_QUAD:    press_quad_reg    <= cfg_data[15:0];
                REG_CROSS_QUAD:    cross_quad_reg    <= cfg_data[15:0];
                REG_PRESS_CUBIC:   press_cubic_reg   <= cfg_data[15:0];
                default:           ;
            endcase
        end
    end

    // scale raw / 253952 toward zero: split |raw| = 31q + r, then q * 2^SH + r * 2^SH / 31
    for (genvar ch = 0; ch < 2; ch++)
    begin : g_scale
        logic [RAW_W-1:0]         abs1_reg;
        logic [RAW_W-1:0]         abs2_reg;
        logic [3:0]               neg_reg;
        logic [RAW_W+RECIP_W-1:0] quo_full;
        logic [QUOT_W-1:0]        quo2_reg;
        logic [QUOT_W-1:0]        quo3_reg;
        logic [RAW_W-1:0]         rem_full;
        logic [REM_W-1:0]         rem3_reg;
        logic [RW+RECIP_W-1:0]    frac_full;
        logic [MW-1:0]            mag4_reg;
        logic signed [PW-1:0]     smp5_reg;

        assign quo_full  = (RAW_W+RECIP_W)'(abs1_reg) * (RAW_W+RECIP_W)'(RECIP);
        assign rem_full  = abs2_reg - ((RAW_W'(quo2_reg) << DIV_SHIFT) - RAW_W'(quo2_reg));
        assign frac_full = (RW+RECIP_W)'({rem3_reg, {SH{1'b0}}}) * (RW+RECIP_W)'(RECIP);

        always_ff @(posedge clk)
        begin
            abs1_reg <= raw[ch][RAW_W-1] ? unsigned'(-raw[ch]) : unsigned'(raw[ch]);
            neg_reg  <= {neg_reg[2:0], raw[ch][RAW_W-1]};
            abs2_reg <= abs1_reg;
            quo2_reg <= quo_full[RECIP_SHIFT +: QUOT_W];
            quo3_reg <= quo2_reg;
            rem3_reg <= rem_full[REM_W-1:0];
            mag4_reg <= {quo3_reg, frac_full[RECIP_SHIFT +: SH]};
            smp5_reg <= neg_reg[3] ? -$signed({1'b0, mag4_reg}) : $signed({1'b0, mag4_reg});
        end

        assign smp[ch] = smp5_reg;
    end

    assign pc30_full = (PW+16)'(smp[0]) * (PW+16)'(press_cubic_reg);
    assign pc21_full = (PW+16)'(smp[0]) * (PW+16)'(cross_quad_reg);
    assign tc01_full = (PW+16)'(smp[1]) * (PW+16)'(temp_on_press_reg);

    assign pd_reg_unused = '0;

    always_ff @(posedge clk)
    begin
        pd_reg[6] <= smp[0];
        for (int k = 7; k <= 11; k++)
        begin
            pd_reg[k] <= pd_reg[k-1];
        end
        td_reg[6] <= smp[1];
        for (int k = 7; k <= 14; k++)
        begin
            td_reg[k] <= td_reg[k-1];
        end

        pc30_reg <= pc30_full[X1W-1:0];
        pc21_reg <= pc21_full[X1W-1:0];
        tc01_reg <= tc01_full[X1W-1:0];

        x1_reg    <= pc30_reg + (X1W'(press_quad_reg) <<< FRAC_BITS);
        y1_reg    <= pc21_reg + (X1W'(cross_lin_reg) <<< FRAC_BITS);
        bd_reg[7] <= tc01_reg + (X1W'(press_offset_reg) <<< FRAC_BITS);
        for (int k = 8; k <= 15; k++)
        begin
            bd_reg[k] <= bd_reg[k-1];
        end

        x2_reg <= $signed(m1[FRAC_BITS +: X2W]) + (X2W'(press_lin_reg) <<< FRAC_BITS);
        z_reg  <= $signed(m2[FRAC_BITS +: ZW]);

        s_reg    <= SW'($signed(m3[FRAC_BITS +: SW-1])) + SW'($signed(m4[FRAC_BITS +: SW-1]));
        pres_reg <= s_reg + SW'(bd_reg[15]) + SW'(pd_reg_unused);
        pint_reg <= pres_rnd[FRAC_BITS +: PRESS_INT_W];

        tc1_reg  <= tc1_full[TSW-1:0];
        tsum_reg <= tc1_reg + (TSW'(c0) <<< (FRAC_BITS - 1));
        tm_reg   <= TMW'(tsum_reg) * TMW'(CENTI);
    end

    bptc_mul #(.WA(PW), .WB(X1W)) u_mul_x1 (.clk(clk), .a(pd_reg[7]), .b(x1_reg), .p(m1));
    bptc_mul #(.WA(PW), .WB(X1W)) u_mul_y1 (.clk(clk), .a(pd_reg[7]), .b(y1_reg), .p(m2));
    bptc_mul #(.WA(PW), .WB(X2W)) u_mul_x2 (.clk(clk), .a(pd_reg[11]), .b(x2_reg), .p(m3));
    bptc_mul #(.WA(PW), .WB(ZW))  u_mul_z  (.clk(clk), .a(td_reg[11]), .b(z_reg), .p(m4));

    assign tc1_full = (PW+12)'(td_reg[14]) * (PW+12)'(c1);

    assign pres_rnd = pres_reg + (pres_reg[SW-1] ? PRESS_RND : SW'(0));
    assign tm_rnd   = tm_reg + (tm_reg[TMW-1] ? TEMP_RND : TMW'(0));
    assign tint     = $signed(tm_rnd[FRAC_BITS +: TEMP_INT_W]);

    always_comb
    begin
        if (pint_reg > PRESS_INT_W'(PRESS_MAX))
            press_next = PRESS_W'(PRESS_MAX);
        else if (pint_reg < PRESS_INT_W'(PRESS_MIN))
            press_next = PRESS_W'(PRESS_MIN);
        else
            press_next = pint_reg[PRESS_W-1:0];

        if (tint > TEMP_INT_W'(TEMP_MAX))
            temp_next = TEMP_W'(TEMP_MAX);
        else if (tint < TEMP_INT_W'(TEMP_MIN))
            temp_next = TEMP_W'(TEMP_MIN);
        else
            temp_next = tint[TEMP_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            press_pa_reg   <= '0;
            temp_centi_reg <= '0;
        end
        else if (vld_reg[LATENCY-1])
        begin
            press_pa_reg   <= press_next;
            temp_centi_reg <= temp_next;
        end
    end

    assign press_pa   = press_pa_reg;
    assign temp_centi = temp_centi_reg;

endmodule

// ===== hdl/bptc_checker.sv =====
// Port-level checks for the compensation core and their binding to it.
module bptc_checker
    import bptc_pkg::*;
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      start,
    input logic                      busy,
    input logic                      done,
    input logic signed [PRESS_W-1:0] press_pa,
    input logic signed [TEMP_W-1:0]  temp_centi
);

    a_done_follows_request: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("accepted request gave no result after the pipeline latency");

    a_done_has_request: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result strobe without a matching request");

    a_ready_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n) |-> !busy)
        else $error("busy raised after reset had been released");

    a_results_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !done |-> ($stable(press_pa) && $stable(temp_centi)))
        else $error("result ports changed without a strobe");

endmodule

bind baro_pressure_temp_compensation_core bptc_checker u_bptc_checker (.*);
